### hw/rtl/hgba_pkg.sv
// Package for the group-by hash aggregator: field widths, action and status codes.
// No dependencies.
`timescale 1ns / 1ps
package hgba_pkg;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned SumW   = 64;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned StatW  = 3;

  localparam logic [1:0] ActClear  = 2'd0;
  localparam logic [1:0] ActAccum  = 2'd1;
  localparam logic [1:0] ActRead   = 2'd2;
  localparam logic [1:0] ActIgnore = 2'd3;

  localparam logic [StatW-1:0] StHit     = 3'd0;
  localparam logic [StatW-1:0] StNew     = 3'd1;
  localparam logic [StatW-1:0] StFull    = 3'd2;
  localparam logic [StatW-1:0] StRead    = 3'd3;
  localparam logic [StatW-1:0] StCleared = 3'd4;

  // One stored entry without its valid bit.
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] count;
    logic [SumW-1:0] sum;
    logic [ValW-1:0] min;
    logic [ValW-1:0] max;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);
endpackage

### hw/rtl/hgba_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on hgba_pkg.
`timescale 1ns / 1ps
interface hgba_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [hgba_pkg::KeyW-1:0]    elem_key;
  logic [hgba_pkg::ValW-1:0]    sum_value;
  logic [hgba_pkg::ValW-1:0]    min_value;
  logic [hgba_pkg::ValW-1:0]    max_value;
  logic [hgba_pkg::IdxW-1:0]    read_index;
  modport source (output valid, action, elem_key, sum_value, min_value, max_value,
                  read_index, input ready);
  modport sink (input valid, action, elem_key, sum_value, min_value, max_value,
                read_index, output ready);
endinterface

interface hgba_out_if;
  logic                          valid;
  logic                          ready;
  logic [hgba_pkg::StatW-1:0]    status;
  logic                          slot_valid;
  logic [hgba_pkg::IdxW-1:0]     slot_index;
  logic [hgba_pkg::KeyW-1:0]     slot_key;
  logic [hgba_pkg::ValW-1:0]     slot_count;
  logic [hgba_pkg::SumW-1:0]     slot_sum;
  logic [hgba_pkg::ValW-1:0]     slot_min;
  logic [hgba_pkg::ValW-1:0]     slot_max;
  modport source (output valid, status, slot_valid, slot_index, slot_key, slot_count,
                  slot_sum, slot_min, slot_max, input ready);
  modport sink (input valid, status, slot_valid, slot_index, slot_key, slot_count,
                slot_sum, slot_min, slot_max, output ready);
endinterface

### hw/rtl/hgba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module hgba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hw/rtl/hash_group_by_aggregator.sv
// Top level of the group-by hash aggregator: probe sequencer and entry memory
// with the valid bit stored beside each entry. Depends on hgba_pkg, hgba_if, hgba_ram.
`timescale 1ns / 1ps
// Usage
//   in_if  (sink): one item per transfer. action 0 clears the table, 1 accumulates
//          elem_key with sum/min/max values, 2 reads the slot at read_index,
//          3 is dropped without a result.
//   out_if (source): one result per clear, accumulate or read item.
// Sequencing
//   One item at a time. A read does a memory read of read_index, then its result.
//   An accumulate first finds the home slot (reciprocal multiply, then
//   remainder), then visits each probed slot (memory read, then check and
//   write-back); it reports a full table once every slot has been probed. A clear
//   rewrites every slot as empty, one per cycle, then shows its result.
// Reset
//   Reset starts the same clearing pass: input ready stays low until the pass
//   ends. Entry data is zeroed by the pass.
// Stall
//   The result waits in the output register; the next item may transfer in
//   meanwhile, and its result holds in the pending slot, with input ready low,
//   until the output register frees.
module hash_group_by_aggregator #(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  hgba_in_if.sink    in_if,
  hgba_out_if.source out_if
);
  localparam int unsigned AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned NW = AW + 1;
  localparam logic [NW-1:0] LastCnt = NW'(TABLE_SLOTS - 1);
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_SLOTS - 1);
  localparam logic [31:0]   Slots32 = 32'(TABLE_SLOTS);
  // Home slot by reciprocal multiplication: q = (key * M) >> (32 + AW) is exact
  // for every 32-bit key with M = floor(2^(32+AW) / TABLE_SLOTS) + 1.
  localparam int unsigned   HashShift = 32 + AW;
  localparam logic [32:0]   HashM = 33'((64'd1 << HashShift) / 64'(TABLE_SLOTS) + 64'd1);

  typedef enum logic [2:0] {
    SInit, SIdle, SHash, SMod, SProbe, SCheck
  } state_e;

  state_e state_q;
  logic [1:0]                 act_q;
  logic [hgba_pkg::KeyW-1:0]  key_q;
  logic [hgba_pkg::ValW-1:0]  sv_q, mnv_q, mxv_q;
  logic [hgba_pkg::IdxW-1:0]  ridx_q;
  logic [AW-1:0]              idx_q;
  logic [NW-1:0]              cnt_q;
  logic                       clr_ack_q;
  logic [65:0]                hash_prod_q;

  // Pending result and output register.
  logic                        res_pend_q;
  logic [hgba_pkg::StatW-1:0]  res_st_q;
  logic                        res_ok_q;
  logic [hgba_pkg::IdxW-1:0]   res_idx_q;
  hgba_pkg::entry_t            res_ent_q;

  logic                        ovld_q;
  logic [hgba_pkg::StatW-1:0]  ost_q;
  logic                        ook_q;
  logic [hgba_pkg::IdxW-1:0]   oidx_q;
  hgba_pkg::entry_t            oent_q;

  // Entry memory: valid bit on top of the entry.
  logic                      we;
  logic [AW-1:0]             raddr;
  logic [hgba_pkg::EntryW:0] wword, rword;
  logic                      mem_vld;
  hgba_pkg::entry_t          mem_ent, upd_ent;

  hgba_ram #(.Width(hgba_pkg::EntryW + 1), .Depth(TABLE_SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q),
    .wdata_i (wword),
    .raddr_i (raddr),
    .rdata_o (rword)
  );

  logic        in_xfer, out_xfer;
  logic        ridx_in;
  logic        rd_ok;
  logic        hit;
  logic        upd;
  logic [31:0] hash_quot, hash_rem;

  assign in_xfer  = in_if.valid && in_if.ready;
  assign out_xfer = out_if.valid && out_if.ready;
  assign in_if.ready = (state_q == SIdle) && !res_pend_q;
  assign ridx_in = (32'(ridx_q) < Slots32);
  assign raddr = (act_q == hgba_pkg::ActRead) ? AW'(ridx_q) : idx_q;
  assign {mem_vld, mem_ent} = rword;
  assign rd_ok = ridx_in && mem_vld;
  assign hit = mem_vld && (mem_ent.key == key_q);
  assign hash_quot = 32'(hash_prod_q >> HashShift);
  assign hash_rem  = key_q - hash_quot * Slots32;

  // Update or create the probed entry.
  always_comb begin
    upd_ent = mem_ent;
    if (hit) begin
      upd_ent.count = mem_ent.count + 32'd1;
      upd_ent.sum   = mem_ent.sum + {32'd0, sv_q};
      if (mnv_q < mem_ent.min) upd_ent.min = mnv_q;
      if (mxv_q > mem_ent.max) upd_ent.max = mxv_q;
    end else begin
      upd_ent.key   = key_q;
      upd_ent.count = 32'd1;
      upd_ent.sum   = {32'd0, sv_q};
      upd_ent.min   = mnv_q;
      upd_ent.max   = mxv_q;
    end
  end
  assign upd = (state_q == SCheck) && (act_q == hgba_pkg::ActAccum) && (hit || !mem_vld);
  // The clearing pass writes an empty slot; otherwise write back the update.
  assign we    = (state_q == SInit) || upd;
  assign wword = (state_q == SInit) ? '0 : {1'b1, upd_ent};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SInit;
      act_q      <= hgba_pkg::ActClear;
      idx_q      <= '0;
      cnt_q      <= '0;
      clr_ack_q  <= 1'b0;
      res_pend_q <= 1'b0;
      ovld_q     <= 1'b0;
    end else begin
      // Advance the pending result into the output register when free.
      if (res_pend_q && (!ovld_q || out_xfer)) begin
        ovld_q     <= 1'b1;
        ost_q      <= res_st_q;
        ook_q      <= res_ok_q;
        oidx_q     <= res_idx_q;
        oent_q     <= res_ent_q;
        res_pend_q <= 1'b0;
      end else if (out_xfer) begin
        ovld_q <= 1'b0;
      end
      case (state_q)
        SInit: begin
          if (idx_q == LastIdx) begin
            state_q <= SIdle;
            if (clr_ack_q) begin
              clr_ack_q  <= 1'b0;
              res_pend_q <= 1'b1;
              res_st_q   <= hgba_pkg::StCleared;
              res_ok_q   <= 1'b0;
              res_idx_q  <= '0;
              res_ent_q  <= '0;
            end
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        SIdle: begin
          if (in_xfer) begin
            act_q  <= in_if.action;
            key_q  <= in_if.elem_key;
            sv_q   <= in_if.sum_value;
            mnv_q  <= in_if.min_value;
            mxv_q  <= in_if.max_value;
            ridx_q <= in_if.read_index;
            cnt_q  <= '0;
            case (in_if.action)
              hgba_pkg::ActClear: begin
                idx_q     <= '0;
                clr_ack_q <= 1'b1;
                state_q   <= SInit;
              end
              hgba_pkg::ActAccum: state_q <= SHash;
              hgba_pkg::ActRead:  state_q <= SProbe;
              default: ;
            endcase
          end
        end
        SHash: begin
          hash_prod_q <= {34'd0, key_q} * {33'd0, HashM};
          state_q     <= SMod;
        end
        SMod: begin
          idx_q   <= AW'(hash_rem);
          state_q <= SProbe;
        end
        SProbe: begin
          // Read issued this cycle at raddr; data arrives next cycle.
          state_q <= SCheck;
        end
        SCheck: begin
          if (act_q == hgba_pkg::ActRead) begin
            res_pend_q <= 1'b1;
            res_st_q   <= hgba_pkg::StRead;
            res_ok_q   <= rd_ok;
            res_idx_q  <= ridx_q;
            res_ent_q  <= rd_ok ? mem_ent : '0;
            state_q    <= SIdle;
          end else if (upd) begin
            res_pend_q <= 1'b1;
            res_st_q   <= hit ? hgba_pkg::StHit : hgba_pkg::StNew;
            res_ok_q   <= 1'b1;
            res_idx_q  <= hgba_pkg::IdxW'(idx_q);
            res_ent_q  <= upd_ent;
            state_q    <= SIdle;
          end else if (cnt_q == LastCnt) begin
            res_pend_q <= 1'b1;
            res_st_q   <= hgba_pkg::StFull;
            res_ok_q   <= 1'b0;
            res_idx_q  <= '0;
            res_ent_q  <= '0;
            state_q    <= SIdle;
          end else begin
            cnt_q   <= cnt_q + NW'(1);
            idx_q   <= (idx_q == LastIdx) ? '0 : idx_q + AW'(1);
            state_q <= SProbe;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign out_if.valid      = ovld_q;
  assign out_if.status     = ost_q;
  assign out_if.slot_valid = ook_q;
  assign out_if.slot_index = oidx_q;
  assign out_if.slot_key   = oent_q.key;
  assign out_if.slot_count = oent_q.count;
  assign out_if.slot_sum   = oent_q.sum;
  assign out_if.slot_min   = oent_q.min;
  assign out_if.slot_max   = oent_q.max;

  // Memory writes happen only in the clearing pass or on the accumulate path.
  a_we_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == SInit) || (act_q == hgba_pkg::ActAccum))
    else $error("write outside accumulate");
  // A new item is never taken while a result is pending.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> !res_pend_q) else $error("overrun");
  // The probe count never exceeds the table size.
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != SCheck || cnt_q <= LastCnt) else $error("probe overrun");
  // A stalled result holds until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.status)
    && $stable(out_if.slot_index)) else $error("result dropped while stalled");
endmodule

### tb/tb.sv
// Testbench for hash_group_by_aggregator: a built-in table model predicts each result.
// Depends on hgba_pkg, hgba_if and the block's RTL.
`timescale 1ns / 1ps
module tb;
  localparam int unsigned Slots = 1024;

  // One result as the block reports it.
  typedef struct packed {
    logic [hgba_pkg::StatW-1:0] status;
    logic                       valid;
    logic [hgba_pkg::IdxW-1:0]  index;
    logic [hgba_pkg::KeyW-1:0]  key;
    logic [hgba_pkg::ValW-1:0]  count;
    logic [hgba_pkg::SumW-1:0]  sum;
    logic [hgba_pkg::ValW-1:0]  min;
    logic [hgba_pkg::ValW-1:0]  max;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hgba_in_if  in_if ();
  hgba_out_if out_if ();

  hash_group_by_aggregator #(.TABLE_SLOTS(Slots)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the group table.
  bit                      grp_valid [Slots];
  bit [hgba_pkg::KeyW-1:0] grp_key  [Slots];
  bit [hgba_pkg::ValW-1:0] grp_count[Slots];
  bit [hgba_pkg::SumW-1:0] grp_sum  [Slots];
  bit [hgba_pkg::ValW-1:0] grp_min  [Slots];
  bit [hgba_pkg::ValW-1:0] grp_max  [Slots];

  result_t pending_results[$];
  bit      failed = 1'b0;
  int      burst_left = 0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;
  int      rx_cycle = 0;
  bit      rx_busy_mode = 1'b0;
  bit [hgba_pkg::KeyW-1:0] key_pool[48];

  // Build the result for one slot; a hidden slot shows only its index.
  function automatic result_t slot_view(logic [hgba_pkg::StatW-1:0] st, int unsigned slot,
                                        bit show);
    result_t r;
    r = '0;
    r.status = st;
    r.index  = slot[hgba_pkg::IdxW-1:0];
    if (show && slot < Slots && grp_valid[slot]) begin
      r.valid = 1'b1;
      r.key   = grp_key[slot];
      r.count = grp_count[slot];
      r.sum   = grp_sum[slot];
      r.min   = grp_min[slot];
      r.max   = grp_max[slot];
    end
    return r;
  endfunction

  // Apply one item to the shadow table and queue the result it causes.
  function automatic void predict_group_update(logic [1:0] act,
                                               logic [hgba_pkg::KeyW-1:0] key,
                                               logic [hgba_pkg::ValW-1:0] sv,
                                               logic [hgba_pkg::ValW-1:0] mnv,
                                               logic [hgba_pkg::ValW-1:0] mxv,
                                               logic [hgba_pkg::IdxW-1:0] ridx);
    int unsigned slot;
    bit done;
    done = 1'b0;
    case (act)
      hgba_pkg::ActClear: begin
        foreach (grp_valid[i]) grp_valid[i] = 1'b0;
        pending_results.push_back(slot_view(hgba_pkg::StCleared, 0, 1'b0));
      end
      hgba_pkg::ActRead: pending_results.push_back(slot_view(hgba_pkg::StRead, ridx, 1'b1));
      hgba_pkg::ActAccum: begin
        slot = key % Slots;
        for (int n = 0; n < Slots && !done; n++) begin
          if (grp_valid[slot] && grp_key[slot] == key) begin
            grp_count[slot] += 1;
            grp_sum[slot]   += hgba_pkg::SumW'(sv);
            if (mnv < grp_min[slot]) grp_min[slot] = mnv;
            if (mxv > grp_max[slot]) grp_max[slot] = mxv;
            pending_results.push_back(slot_view(hgba_pkg::StHit, slot, 1'b1));
            done = 1'b1;
          end else if (!grp_valid[slot]) begin
            grp_valid[slot] = 1'b1;
            grp_key[slot]   = key;
            grp_count[slot] = 1;
            grp_sum[slot]   = hgba_pkg::SumW'(sv);
            grp_min[slot]   = mnv;
            grp_max[slot]   = mxv;
            pending_results.push_back(slot_view(hgba_pkg::StNew, slot, 1'b1));
            done = 1'b1;
          end else begin
            slot = (slot + 1 >= Slots) ? 0 : slot + 1;
          end
        end
        if (!done) pending_results.push_back(slot_view(hgba_pkg::StFull, 0, 1'b0));
      end
      default: ;  // unknown action: dropped, no result
    endcase
  endfunction

  // Offer one item and hold it until the block takes it; the sender runs in bursts.
  task automatic send_item(logic [1:0] act, logic [hgba_pkg::KeyW-1:0] key,
                           logic [hgba_pkg::ValW-1:0] sv, logic [hgba_pkg::ValW-1:0] mnv,
                           logic [hgba_pkg::ValW-1:0] mxv,
                           logic [hgba_pkg::IdxW-1:0] ridx);
    bit rdy;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.elem_key   <= key;
    in_if.sum_value  <= sv;
    in_if.min_value  <= mnv;
    in_if.max_value  <= mxv;
    in_if.read_index <= ridx;
    do begin
      @(negedge clk_i);
      rdy = in_if.ready;
      @(posedge clk_i);
    end while (!rdy);
    predict_group_update(act, key, sv, mnv, mxv, ridx);
  endtask

  // Stop offering and wait until every queued result has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic accum(logic [hgba_pkg::KeyW-1:0] key, logic [hgba_pkg::ValW-1:0] sv,
                       logic [hgba_pkg::ValW-1:0] mnv, logic [hgba_pkg::ValW-1:0] mxv);
    send_item(hgba_pkg::ActAccum, key, sv, mnv, mxv, '0);
  endtask

  task automatic read_slot(logic [hgba_pkg::IdxW-1:0] idx);
    send_item(hgba_pkg::ActRead, $urandom, $urandom, $urandom, $urandom, idx);
  endtask

  // Extremes, wraparound probing, all-ones key, empty reads, dropped action.
  task automatic test_directed();
    send_item(hgba_pkg::ActClear, '1, '1, '1, '1, '1);
    read_slot(10'd0);
    read_slot(10'd1023);
    accum(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    accum(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    accum(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);        // home is the last slot
    accum(32'd1023, 32'd7, 32'd5, 32'd9);             // collides, wraps to slot 0 then 1
    accum(32'd2047, 32'd1, 32'd2, 32'd3);
    send_item(hgba_pkg::ActIgnore, 32'd55, 32'd1, 32'd1, 32'd1, 10'd3);  // dropped item
    accum(32'd1023, 32'd3, 32'd9, 32'd1);
    accum(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    read_slot(10'd0);
    read_slot(10'd1);
    read_slot(10'd2);
    read_slot(10'd1023);
    read_slot(10'd512);
    send_item(hgba_pkg::ActClear, '0, '0, '0, '0, '0);
    read_slot(10'd0);
    accum(32'd0, 32'd1, 32'd1, 32'd1);
    drain_results();
  endtask

  // Fill every slot, then probe a full table for a miss and a hit.
  task automatic test_table_full();
    send_item(hgba_pkg::ActClear, '0, '0, '0, '0, '0);
    for (int i = 0; i < Slots; i++)
      accum({$urandom_range(1, 4000000)} << 10 | i, $urandom, $urandom, $urandom);
    accum(32'h1234_5678, 32'd1, 32'd1, 32'd1);
    accum(grp_key[Slots - 1], 32'd2, 32'd0, 32'hFFFF_FFFF);
    accum(grp_key[5], 32'd4, 32'd4, 32'd4);
    read_slot(10'd1023);
    read_slot(10'd5);
    send_item(hgba_pkg::ActClear, '0, '0, '0, '0, '0);
    drain_results();
  endtask

  // Hold the receiver off for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0) read_slot(hgba_pkg::IdxW'($urandom_range(0, 15)));
      else accum($urandom_range(0, 15), $urandom, $urandom, $urandom);
    end
    drain_results();
  endtask

  // Mostly accumulates over a small, colliding key pool; some reads, clears, noise.
  task automatic test_random(int n_items);
    int unsigned pick;
    logic [hgba_pkg::KeyW-1:0] key;
    foreach (key_pool[i])
      key_pool[i] = (i < 24) ? (($urandom << 10) | (10'd1020 + i % 6)) : $urandom;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      key  = key_pool[$urandom_range(0, 47)];
      if (pick < 2) begin
        send_item(hgba_pkg::ActClear, $urandom, $urandom, $urandom, $urandom,
                  hgba_pkg::IdxW'($urandom));
      end else if (pick < 4) begin
        send_item(hgba_pkg::ActIgnore, $urandom, $urandom, $urandom, $urandom,
                  hgba_pkg::IdxW'($urandom));
      end else if (pick < 24) begin
        read_slot((pick < 18) ? hgba_pkg::IdxW'(key % Slots + $urandom_range(0, 4))
                              : hgba_pkg::IdxW'($urandom));
      end else begin
        if (pick > 96) key = $urandom;
        accum(key, $urandom, $urandom, $urandom);
      end
    end
    drain_results();
  endtask

  // Receiver: alternate stretches of steady ready and random stalls; long hold on request.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 80 == 0) rx_busy_mode <= ($urandom_range(0, 2) != 0);
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= 300;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rx_busy_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  // Sample the result channel mid-cycle and check each transfer in order.
  always begin
    result_t got;
    result_t want;
    bit take;
    @(negedge clk_i);
    take = rst_ni && out_if.valid && out_if.ready;
    got = '{out_if.status, out_if.slot_valid, out_if.slot_index, out_if.slot_key,
            out_if.slot_count, out_if.slot_sum, out_if.slot_min, out_if.slot_max};
    @(posedge clk_i);
    if (take) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: status %0d index %0d", got.status, got.index);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status); failed = 1'b1;
        end
        if (got.valid !== want.valid) begin
          $error("slot_valid: expected %0d, got %0d", want.valid, got.valid); failed = 1'b1;
        end
        if (got.index !== want.index) begin
          $error("slot_index: expected %0d, got %0d", want.index, got.index); failed = 1'b1;
        end
        if (got.key !== want.key) begin
          $error("slot_key: expected %h, got %h", want.key, got.key); failed = 1'b1;
        end
        if (got.count !== want.count) begin
          $error("slot_count: expected %0d, got %0d", want.count, got.count); failed = 1'b1;
        end
        if (got.sum !== want.sum) begin
          $error("slot_sum: expected %h, got %h", want.sum, got.sum); failed = 1'b1;
        end
        if (got.min !== want.min) begin
          $error("slot_min: expected %h, got %h", want.min, got.min); failed = 1'b1;
        end
        if (got.max !== want.max) begin
          $error("slot_max: expected %h, got %h", want.max, got.max); failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #(30_000_000);
    $display("FAIL");
    $finish;
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.action     = hgba_pkg::ActClear;
    in_if.elem_key   = '0;
    in_if.sum_value  = '0;
    in_if.min_value  = '0;
    in_if.max_value  = '0;
    in_if.read_index = '0;
    out_if.ready     = 1'b0;
    foreach (grp_valid[i]) grp_valid[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(400);
    test_table_full();
    test_random(400);
    repeat (20) @(posedge clk_i);
    if (!failed && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
